[src/wdalu_pkg.sv]
// ----------------------------------------------------------------------------
// wdalu_pkg
// Shared types and codes for the word ALU: mode codes, operation classes,
// status selection and the control word that travels with each item.
// ----------------------------------------------------------------------------
package wdalu_pkg;

    typedef enum logic [3:0] {
        MODE_ADD    = 4'd0,
        MODE_SUB    = 4'd1,
        MODE_MUL    = 4'd2,
        MODE_DIV    = 4'd3,
        MODE_SWAP   = 4'd4,
        MODE_CMP    = 4'd5,
        MODE_MIN    = 4'd6,
        MODE_MAX    = 4'd7,
        MODE_CLAMP  = 4'd8,
        MODE_ZERO   = 4'd9,
        MODE_SATADD = 4'd10,
        MODE_SATSUB = 4'd11,
        MODE_INC    = 4'd12,
        MODE_DEC    = 4'd13
    } mode_t;

    typedef enum logic [1:0] {
        OPC_DIRECT,
        OPC_MUL,
        OPC_DIV
    } op_class_t;

    typedef enum logic [1:0] {
        ST_RES_HIGH,
        ST_SEC_HIGH,
        ST_CODE
    } status_sel_t;

    localparam logic [7:0] CMP_EQ = 8'd0;
    localparam logic [7:0] CMP_GT = 8'd1;
    localparam logic [7:0] CMP_LT = 8'd255;

    typedef struct packed {
        op_class_t   cls;
        status_sel_t st_sel;
        logic [7:0]  code;
    } item_ctl_t;

endpackage

[src/word16_alu_core.sv]
// ----------------------------------------------------------------------------
// word16_alu_core
// Unsigned word ALU with wrapping, saturating, compare and divide modes.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, one item per clock.
// Every item's result appears on the result ports, marked by done, once it
// has passed the queue, the execution stages and the output register,
// in order and for one cycle only; the receiver cannot stall, so capture it
// then. The execution pipeline resolves one multiplier bit or one quotient
// bit per stage over WORD_WIDTH stages; all modes travel through it so results
// keep their order. busy comes from the two-entry queue between decode and
// execution and stays low in practice.
// ----------------------------------------------------------------------------
module word16_alu_core
    import wdalu_pkg::*;
#(
    parameter int WORD_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [3:0]            mode,
    input  logic [WORD_WIDTH-1:0] operand_a,
    input  logic [WORD_WIDTH-1:0] operand_b,
    input  logic [WORD_WIDTH-1:0] operand_c,
    output logic                  done,
    output logic [WORD_WIDTH-1:0] result_value,
    output logic [WORD_WIDTH-1:0] second_value,
    output logic [7:0]            status_byte
);

    localparam int CTL_W = $bits(item_ctl_t);
    localparam int Q_W   = CTL_W + 4 * WORD_WIDTH;

    logic                  q_full;
    logic                  q_empty;
    logic                  push;
    item_ctl_t             f_ctl;
    logic [WORD_WIDTH-1:0] f_res;
    logic [WORD_WIDTH-1:0] f_sec;
    logic [Q_W-1:0]        q_wr;
    logic [Q_W-1:0]        q_rd;
    item_ctl_t             b_ctl;
    logic [WORD_WIDTH-1:0] b_a;
    logic [WORD_WIDTH-1:0] b_b;
    logic [WORD_WIDTH-1:0] b_res;
    logic [WORD_WIDTH-1:0] b_sec;

    wdalu_front #(.WORD_WIDTH(WORD_WIDTH)) u_front
    (
        .start     (start),
        .q_full    (q_full),
        .busy      (busy),
        .push      (push),
        .mode      (mode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .operand_c (operand_c),
        .ctl       (f_ctl),
        .res       (f_res),
        .sec       (f_sec)
    );

    assign q_wr = {f_ctl, operand_a, operand_b, f_res, f_sec};

    // the back pipeline never stalls: drain one item every cycle
    wdalu_fifo #(.WIDTH(Q_W)) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (q_wr),
        .pop     (!q_empty),
        .rd_data (q_rd),
        .empty   (q_empty),
        .full    (q_full)
    );

    assign {b_ctl, b_a, b_b, b_res, b_sec} = q_rd;

    wdalu_back #(.WORD_WIDTH(WORD_WIDTH)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (!q_empty),
        .in_ctl       (b_ctl),
        .in_a         (b_a),
        .in_b         (b_b),
        .in_res       (b_res),
        .in_sec       (b_sec),
        .done         (done),
        .result_value (result_value),
        .second_value (second_value),
        .status_byte  (status_byte)
    );

endmodule

[src/wdalu_front.sv]
// ----------------------------------------------------------------------------
// wdalu_front
// Accepts items, decodes the mode and works out combinationally every
// operation but multiply and divide, which are tagged for the back pipeline.
// ----------------------------------------------------------------------------
module wdalu_front
    import wdalu_pkg::*;
#(
    parameter int WORD_WIDTH = 16
)
(
    input  logic                  start,
    input  logic                  q_full,
    output logic                  busy,
    output logic                  push,
    input  logic [3:0]            mode,
    input  logic [WORD_WIDTH-1:0] operand_a,
    input  logic [WORD_WIDTH-1:0] operand_b,
    input  logic [WORD_WIDTH-1:0] operand_c,
    output item_ctl_t             ctl,
    output logic [WORD_WIDTH-1:0] res,
    output logic [WORD_WIDTH-1:0] sec
);

    localparam logic [WORD_WIDTH-1:0] ONES = '1;

    logic [WORD_WIDTH:0]   sum;
    logic [WORD_WIDTH-1:0] lo_bound;
    logic                  a_lt_b;

    assign busy = q_full;
    assign push = start && !q_full;

    assign sum      = {1'b0, operand_a} + {1'b0, operand_b};
    assign a_lt_b   = operand_a < operand_b;
    assign lo_bound = a_lt_b ? operand_b : operand_a;

    always_comb
    begin
        ctl.cls    = OPC_DIRECT;
        ctl.st_sel = ST_RES_HIGH;
        ctl.code   = CMP_EQ;
        res        = '0;
        sec        = '0;
        unique case (mode_t'(mode))
            MODE_ADD:    res = sum[WORD_WIDTH-1:0];
            MODE_SUB:    res = operand_a - operand_b;
            MODE_MUL:    ctl.cls = OPC_MUL;
            MODE_DIV:
            begin
                // hold the dividend: it is the answer for a zero divisor
                ctl.cls = OPC_DIV;
                res     = operand_a;
            end
            MODE_SWAP:
            begin
                res        = operand_b;
                sec        = operand_a;
                ctl.st_sel = ST_SEC_HIGH;
            end
            MODE_CMP:
            begin
                ctl.st_sel = ST_CODE;
                if (operand_a == operand_b)
                    ctl.code = CMP_EQ;
                else if (a_lt_b)
                    ctl.code = CMP_LT;
                else
                    ctl.code = CMP_GT;
            end
            MODE_MIN:    res = a_lt_b ? operand_a : operand_b;
            MODE_MAX:    res = a_lt_b ? operand_b : operand_a;
            MODE_CLAMP:  res = (lo_bound > operand_c) ? operand_c : lo_bound;
            MODE_SATADD: res = sum[WORD_WIDTH] ? ONES : sum[WORD_WIDTH-1:0];
            MODE_SATSUB: res = a_lt_b ? '0 : operand_a - operand_b;
            MODE_INC:    res = (operand_a == ONES) ? operand_a : operand_a + 1'b1;
            MODE_DEC:    res = (operand_a == '0) ? '0 : operand_a - 1'b1;
            default:     ctl.st_sel = ST_CODE;
        endcase
    end

endmodule

[src/wdalu_fifo.sv]
// ----------------------------------------------------------------------------
// wdalu_fifo
// Two-entry queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
module wdalu_fifo
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_pop;

    assign empty   = count_reg == 2'd0;
    assign full    = count_reg == 2'd2;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

[src/wdalu_back.sv]
// ----------------------------------------------------------------------------
// wdalu_back
// Fixed-latency execution pipeline: one multiplier bit or one quotient bit
// per stage, WORD_WIDTH stages, then the output register.
// ----------------------------------------------------------------------------
module wdalu_back
    import wdalu_pkg::*;
#(
    parameter int WORD_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  item_ctl_t             in_ctl,
    input  logic [WORD_WIDTH-1:0] in_a,
    input  logic [WORD_WIDTH-1:0] in_b,
    input  logic [WORD_WIDTH-1:0] in_res,
    input  logic [WORD_WIDTH-1:0] in_sec,
    output logic                  done,
    output logic [WORD_WIDTH-1:0] result_value,
    output logic [WORD_WIDTH-1:0] second_value,
    output logic [7:0]            status_byte
);

    localparam int W = WORD_WIDTH;

    // stage registers; fa: multiplicand or dividend, fb: multiplier or divisor,
    // acc: product or remainder, quo: quotient
    logic            vld_reg [W];
    item_ctl_t       ctl_reg [W];
    logic [W-1:0]    fa_reg  [W];
    logic [W-1:0]    fb_reg  [W];
    logic [W-1:0]    acc_reg [W];
    logic [W-1:0]    quo_reg [W];
    logic [W-1:0]    res_reg [W];
    logic [W-1:0]    sec_reg [W];

    logic            src_vld [W];
    item_ctl_t       src_ctl [W];
    logic [W-1:0]    src_fa  [W];
    logic [W-1:0]    src_fb  [W];
    logic [W-1:0]    src_acc [W];
    logic [W-1:0]    src_quo [W];
    logic [W-1:0]    src_res [W];
    logic [W-1:0]    src_sec [W];

    logic [W-1:0]    fa_next  [W];
    logic [W-1:0]    fb_next  [W];
    logic [W-1:0]    acc_next [W];
    logic [W-1:0]    quo_next [W];
    logic [W:0]      trial    [W];
    logic [W:0]      diff     [W];
    logic [W-1:0]    prod_sum [W];

    logic            done_reg;
    logic [W-1:0]    result_reg;
    logic [W-1:0]    second_reg;
    logic [7:0]      status_reg;
    logic [W-1:0]    final_res;
    logic [7:0]      final_st;
    item_ctl_t       last_ctl;

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            if (i == 0)
            begin
                src_vld[i] = in_valid;
                src_ctl[i] = in_ctl;
                src_fa[i]  = in_a;
                src_fb[i]  = in_b;
                src_acc[i] = '0;
                src_quo[i] = '0;
                src_res[i] = in_res;
                src_sec[i] = in_sec;
            end
            else
            begin
                src_vld[i] = vld_reg[i-1];
                src_ctl[i] = ctl_reg[i-1];
                src_fa[i]  = fa_reg[i-1];
                src_fb[i]  = fb_reg[i-1];
                src_acc[i] = acc_reg[i-1];
                src_quo[i] = quo_reg[i-1];
                src_res[i] = res_reg[i-1];
                src_sec[i] = sec_reg[i-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            prod_sum[i] = src_acc[i] + (src_fb[i][0] ? src_fa[i] : '0);
            trial[i]    = {src_acc[i], src_fa[i][W-1]};
            diff[i]     = trial[i] - {1'b0, src_fb[i]};
            fa_next[i]  = src_fa[i];
            fb_next[i]  = src_fb[i];
            acc_next[i] = src_acc[i];
            quo_next[i] = src_quo[i];
            unique case (src_ctl[i].cls)
                OPC_MUL:
                begin
                    fa_next[i]  = {src_fa[i][W-2:0], 1'b0};
                    fb_next[i]  = {1'b0, src_fb[i][W-1:1]};
                    acc_next[i] = prod_sum[i];
                end
                OPC_DIV:
                begin
                    // restoring step: bring down the next dividend bit
                    fa_next[i]  = {src_fa[i][W-2:0], 1'b0};
                    acc_next[i] = diff[i][W] ? trial[i][W-1:0] : diff[i][W-1:0];
                    quo_next[i] = {src_quo[i][W-2:0], !diff[i][W]};
                end
                default:
                begin
                    fa_next[i] = src_fa[i];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < W; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < W; i++)
                vld_reg[i] <= src_vld[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < W; i++)
        begin
            ctl_reg[i] <= src_ctl[i];
            fa_reg[i]  <= fa_next[i];
            fb_reg[i]  <= fb_next[i];
            acc_reg[i] <= acc_next[i];
            quo_reg[i] <= quo_next[i];
            res_reg[i] <= src_res[i];
            sec_reg[i] <= src_sec[i];
        end
    end

    assign last_ctl = ctl_reg[W-1];

    always_comb
    begin
        unique case (last_ctl.cls)
            OPC_MUL: final_res = acc_reg[W-1];
            OPC_DIV: final_res = (fb_reg[W-1] == '0) ? res_reg[W-1] : quo_reg[W-1];
            default: final_res = res_reg[W-1];
        endcase
    end

    always_comb
    begin
        unique case (last_ctl.st_sel)
            ST_RES_HIGH: final_st = final_res[W-1 -: 8];
            ST_SEC_HIGH: final_st = sec_reg[W-1][W-1 -: 8];
            default:     final_st = last_ctl.code;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[W-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= final_res;
        second_reg <= sec_reg[W-1];
        status_reg <= final_st;
    end

    assign done         = done_reg;
    assign result_value = result_reg;
    assign second_value = second_reg;
    assign status_byte  = status_reg;

endmodule

[src/wdalu_check.sv]
// ----------------------------------------------------------------------------
// wdalu_check
// Port-level checks on the word ALU, bound to the top level.
// ----------------------------------------------------------------------------
module wdalu_check
    import wdalu_pkg::*;
#(
    parameter int WORD_WIDTH = 16
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [3:0]            mode,
    input logic [WORD_WIDTH-1:0] operand_a,
    input logic [WORD_WIDTH-1:0] operand_b,
    input logic                  done,
    input logic [WORD_WIDTH-1:0] result_value,
    input logic [WORD_WIDTH-1:0] second_value,
    input logic [7:0]            status_byte
);

    localparam int LAT = WORD_WIDTH + 2;

    // every taken item comes out after the fixed latency
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("taken item produced no result");

    // no result without a taken item
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a taken item");

    // execution drains every cycle, so the queue never fills
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("queue filled");

    a_cmp_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(mode, LAT) == MODE_CMP) |->
            (result_value == '0 && second_value == '0 &&
             (status_byte == CMP_EQ || status_byte == CMP_GT || status_byte == CMP_LT)))
        else $error("compare result malformed");

    a_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(mode, LAT) == MODE_SWAP) |->
            (result_value == $past(operand_b, LAT) && second_value == $past(operand_a, LAT)))
        else $error("swap result wrong");

endmodule

bind word16_alu_core wdalu_check #(.WORD_WIDTH(WORD_WIDTH)) u_wdalu_check (.*);
